// ===== src/sqt_pkg.sv =====
package sqt_pkg;

	localparam int TREE_NODES = 15;
	localparam int NODE_W     = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
	localparam int RANK_W     = 4;
	localparam int SAMPLE_W   = 64;
	localparam int EST_W      = 32;

	localparam logic [EST_W-1:0] STEP_FLOOR_NEW = 32'd1024;
	localparam logic [EST_W-1:0] EST_MAX        = 32'hFFFF_FFFF;
	localparam logic [EST_W-1:0] STEP_MIN       = 32'd1;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef logic [NODE_W-1:0] node_idx_t;
	typedef logic [TREE_NODES-1:0][NODE_W-1:0] order_tbl_t;

	// result of one node visit
	typedef struct packed {
		logic [EST_W-1:0] est;
		logic [EST_W-1:0] step;
		logic             stop;
	} node_upd_t;

	// node index for each in-order position of the breadth-first tree
	function automatic order_tbl_t build_order();
		order_tbl_t tbl;
		int         i;
		int         k;
		tbl = '0;
		i   = 0;
		while (2 * i + 1 < TREE_NODES) i = 2 * i + 1;
		for (k = 0; k < TREE_NODES; k++) begin
			tbl[k] = NODE_W'(i);
			if (2 * i + 2 < TREE_NODES) begin
				i = 2 * i + 2;
				while (2 * i + 1 < TREE_NODES) i = 2 * i + 1;
			end else begin
				// climb while coming from a right child, then one more step up
				while (i > 0 && (i & 1) == 0) i = (i - 1) >> 1;
				if (i > 0) i = (i - 1) >> 1;
			end
		end
		return tbl;
	endfunction

	localparam order_tbl_t SORT_ORDER = build_order();

endpackage

// ===== src/sqt_node_upd.sv =====
module sqt_node_upd import sqt_pkg::*; (
	input  logic [EST_W-1:0]    est,
	input  logic [EST_W-1:0]    step,
	input  logic [SAMPLE_W-1:0] sample,
	output node_upd_t           upd
);

	logic              v_hi;
	logic [EST_W:0]    v_lo;
	logic [EST_W:0]    m_ext;
	logic              m_gt_v;
	logic              m_lt_v;
	logic [EST_W-1:0]  half;
	logic [EST_W:0]    sum;
	logic [EST_W-1:0]  m_new;
	logic [EST_W-1:0]  s_new;
	logic [EST_W:0]    m_new_ext;
	logic [EST_W:0]    diff;
	logic              diff_lt;
	logic [EST_W-1:0]  s_half;

	// a sample at or above 2^33 is farther than any step from any estimate
	assign v_hi   = |sample[SAMPLE_W-1:EST_W+1];
	assign v_lo   = sample[EST_W:0];
	assign m_ext  = {1'b0, est};
	assign m_gt_v = !v_hi && (m_ext > v_lo);
	assign m_lt_v = v_hi || (m_ext < v_lo);
	assign half   = sample[EST_W:1];
	assign sum    = m_ext + {1'b0, step};

	always_comb begin
		m_new = est;
		s_new = step;
		if (step == '0) begin
			m_new = sample[EST_W-1:0];
			s_new = (half > STEP_FLOOR_NEW) ? half : STEP_FLOOR_NEW;
		end else if (m_gt_v) begin
			m_new = (est >= step) ? est - step : '0;
		end else if (m_lt_v) begin
			m_new = sum[EST_W] ? EST_MAX : sum[EST_W-1:0];
		end
	end

	assign m_new_ext = {1'b0, m_new};
	assign diff      = (m_new_ext > v_lo) ? m_new_ext - v_lo : v_lo - m_new_ext;
	assign diff_lt   = !v_hi && (diff < {1'b0, s_new});
	assign s_half    = (s_new >> 1) == '0 ? STEP_MIN : (s_new >> 1);

	assign upd.est  = m_new;
	assign upd.step = diff_lt ? s_half : s_new;
	assign upd.stop = v_hi || (v_lo >= m_new_ext);

endmodule

// ===== src/streaming_quantile_tree.sv =====
// Streaming quantile tree: a breadth-first binary tree of 32-bit estimates,
// each with its own step, refined by stochastic approximation.
//
// Input channel (in_valid/in_ready): one request per handshake. req_type
// selects an add (sample_value) or a read (rank). in_ready is high only
// while the sequencer is idle; one request is processed at a time.
// Add: the shared node-update unit visits one node per cycle down the left
// spine, 1 to 4 of the 15 nodes (tree depth), no result.
// Read: one sorted position per cycle through a max compare, positions 0 to
// rank (rank clamped to the last position); the result shows on out_valid
// when the walk ends and the output register is free.
// A new request waits while one is in flight: in_ready returns the cycle
// after the walk ends.
// Output channel (out_valid/out_ready): quantile_value and rank_echo sit in
// an output register. New requests are taken while it waits; a read that
// finishes while the register is still full holds its last step until the
// receiver takes the pending result.
// Reset (arst_n low, asynchronous) clears all estimates and steps (all
// nodes unused) and drops any pending result.
module streaming_quantile_tree import sqt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic [RANK_W-1:0]   rank,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [EST_W-1:0]    quantile_value,
	output logic [RANK_W-1:0]   rank_echo
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ADD  = 3'b010,
		ST_READ = 3'b100
	} state_t;

	state_t              state_q;
	logic [EST_W-1:0]    est_q  [TREE_NODES];
	logic [EST_W-1:0]    step_q [TREE_NODES];
	logic [SAMPLE_W-1:0] sample_q;
	node_idx_t           node_q;
	node_idx_t           cnt_q;
	node_idx_t           last_q;
	logic [EST_W-1:0]    best_q;
	logic [RANK_W-1:0]   rank_q;
	logic                out_valid_q;
	logic [EST_W-1:0]    quantile_q;
	logic [RANK_W-1:0]   rank_echo_q;

	node_upd_t           upd;
	logic [NODE_W:0]     next_node;
	logic                add_done;
	logic [EST_W-1:0]    rd_est;
	logic [EST_W-1:0]    rd_best;
	logic                out_free;
	logic                rd_done;
	logic                accept;
	node_idx_t           last_d;

	// shared node-update unit, one tree level per cycle
	sqt_node_upd u_upd (
		.est    (est_q[node_q]),
		.step   (step_q[node_q]),
		.sample (sample_q),
		.upd    (upd)
	);

	// the walk only ever continues to the left child
	assign next_node = {node_q, 1'b1};
	assign add_done  = upd.stop || (32'(next_node) >= TREE_NODES);

	assign rd_est   = est_q[SORT_ORDER[cnt_q]];
	assign rd_best  = (rd_est > best_q) ? rd_est : best_q;
	assign out_free = !out_valid_q || out_ready;
	// read walk ends and its result moves into the output register
	assign rd_done  = (state_q == ST_READ) && (cnt_q == last_q) && out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// clamp a rank beyond the tree to the last sorted position
	assign last_d = (32'(rank) >= TREE_NODES) ? NODE_W'(TREE_NODES - 1) : NODE_W'(rank);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TREE_NODES; i++) begin
				est_q[i]  <= '0;
				step_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready && !rd_done) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req_type == REQ_READ) ? ST_READ : ST_ADD;
					end
				end
				ST_ADD: begin
					est_q[node_q]  <= upd.est;
					step_q[node_q] <= upd.step;
					if (add_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (cnt_q == last_q) begin
						// hold here until the output register frees up
						if (out_free) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_value;
			rank_q   <= rank;
			last_q   <= last_d;
			node_q   <= '0;
			cnt_q    <= '0;
			best_q   <= '0;
		end
		if (state_q == ST_ADD) begin
			node_q <= next_node[NODE_W-1:0];
		end
		if (state_q == ST_READ) begin
			if (cnt_q == last_q) begin
				if (out_free) begin
					quantile_q  <= rd_best;
					rank_echo_q <= rank_q;
				end
			end else begin
				best_q <= rd_best;
				cnt_q  <= cnt_q + 1'b1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign quantile_value = quantile_q;
	assign rank_echo      = rank_echo_q;

endmodule

// ===== src/sqt_chk.sv =====
module sqt_chk import sqt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                req_type,
	input logic [SAMPLE_W-1:0] sample_value,
	input logic [RANK_W-1:0]   rank,
	input logic                out_valid,
	input logic                out_ready,
	input logic [EST_W-1:0]    quantile_value,
	input logic [RANK_W-1:0]   rank_echo
);

	// a waiting request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(req_type) && $stable(sample_value)
			&& $stable(rank))
		else $error("waiting request changed");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quantile_value) && $stable(rank_echo))
		else $error("stalled result changed");

	// every request taken makes the block busy in the cycle after it
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted on back-to-back cycles");

	// no result appears right after a request is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// an add raises no result at the end of its first node visit
	a_add_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == REQ_ADD |=> ##1 !$rose(out_valid))
		else $error("add request produced a result");

endmodule

bind streaming_quantile_tree sqt_chk u_sqt_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.req_type       (req_type),
	.sample_value   (sample_value),
	.rank           (rank),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.quantile_value (quantile_value),
	.rank_echo      (rank_echo)
);
